// File: rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants for the prime sieve filter chain: the beat that
// moves one candidate bit from cell to cell, and the default sizes.
// ----------------------------------------------------------------------------
package psf_pkg;

   // Default chain length and internal value width
   localparam int NUM_CELLS_DEF   = 2048;
   localparam int VALUE_WIDTH_DEF = 16;

   // Width of the candidate and prime fields on the ports
   localparam int FIELD_W = 16;

   // Widest internal value, used to extend or cut values between widths
   localparam int EXT_W = 64;

   // One bit of a candidate, MSB first, with the tags of its item.
   // The drop and stored tags are final on the last beat only.
   typedef struct packed {
      logic valid;   // beat carries a candidate bit
      logic data;    // candidate bit
      logic first;   // MSB of the candidate
      logic last;    // LSB of the candidate
      logic eos;     // item ends the stream
      logic drop;    // below two, or divided by a stored prime
      logic stored;  // item already took a free cell
   } beat_type;

endpackage

// File: rtl/psf_feed.sv
// ----------------------------------------------------------------------------
// psf_feed
// Input stage: takes one candidate beat and shifts it into the chain MSB
// first, one bit per cycle while the chain advances, tagged with its end-of-stream mark.
// ----------------------------------------------------------------------------
module psf_feed #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_candidate,
   input  logic                req_end_of_stream,
   output psf_pkg::beat_type   feed_beat
);
   import psf_pkg::*;

   localparam int CntW = $clog2(VALUE_WIDTH + 1);
   localparam logic [CntW-1:0] Beats = CntW'(VALUE_WIDTH);
   localparam logic [CntW-1:0] OneLeft = CntW'(1);

   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CntW-1:0]        left_ff, left_in;
   logic                   eos_ff, eos_in;
   logic                   drop_ff, drop_in;
   logic [EXT_W-1:0]       cand_ext;
   logic [VALUE_WIDTH-1:0] cand;
   logic                   load;

   // Keep the low VALUE_WIDTH bits of the candidate
   assign cand_ext = EXT_W'(req_candidate);
   assign cand     = cand_ext[VALUE_WIDTH-1:0];

   // Take a new beat when idle or while the last bit goes out
   assign req_ready = advance && ((left_ff == '0) || (left_ff == OneLeft));
   assign load      = req_valid && req_ready;

   // Present the current bit to the first cell
   always_comb begin
      feed_beat.valid  = (left_ff != '0);
      feed_beat.data   = val_ff[VALUE_WIDTH-1];
      feed_beat.first  = (left_ff == Beats);
      feed_beat.last   = (left_ff == OneLeft);
      feed_beat.eos    = eos_ff;
      feed_beat.drop   = drop_ff;
      feed_beat.stored = 1'b0;
   end

   // Load a new candidate or shift out the next bit
   always_comb begin
      val_in  = val_ff;
      left_in = left_ff;
      eos_in  = eos_ff;
      drop_in = drop_ff;
      if (advance) begin
         if (load) begin
            val_in  = cand;
            left_in = Beats;
            eos_in  = req_end_of_stream;
            drop_in = (cand[VALUE_WIDTH-1:1] == '0);
         end else if (left_ff != '0) begin
            val_in  = {val_ff[VALUE_WIDTH-2:0], 1'b0};
            left_in = left_ff - OneLeft;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      eos_ff  <= eos_in;
      drop_ff <= drop_in;
   end

endmodule

// File: rtl/psf_cell.sv
// ----------------------------------------------------------------------------
// psf_cell
// One sieve cell. A used cell holds a prime and forms the remainder of the
// passing candidate one bit per cycle while the chain advances; a free cell shifts
// the candidate in and claims it on its last beat unless it was dropped or already stored.
// ----------------------------------------------------------------------------
module psf_cell #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  psf_pkg::beat_type up_beat,
   output psf_pkg::beat_type down_beat
);
   import psf_pkg::*;

   logic [VALUE_WIDTH-1:0] prime_ff, prime_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic                   used_ff, used_in;
   beat_type               pass_ff, pass_in;
   logic [VALUE_WIDTH-1:0] rem_base;
   logic [VALUE_WIDTH:0]   trial, divisor, diff;
   logic [VALUE_WIDTH-1:0] step_rem;
   logic                   hit_here, claim;

   // One restoring division step on the incoming bit
   always_comb begin
      rem_base = up_beat.first ? '0 : rem_ff;
      trial    = {rem_base, up_beat.data};
      divisor  = {1'b0, prime_ff};
      diff     = trial - divisor;
      step_rem = (trial >= divisor) ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
   end

   // Decide divide or claim on the last beat
   assign hit_here = up_beat.valid && up_beat.last && used_ff && (step_rem == '0);
   assign claim    = up_beat.valid && up_beat.last && !used_ff &&
                     !up_beat.drop && !up_beat.stored;

   always_comb begin
      prime_in       = prime_ff;
      rem_in         = rem_ff;
      used_in        = used_ff;
      pass_in        = up_beat;
      pass_in.drop   = up_beat.drop | hit_here;
      pass_in.stored = up_beat.stored | claim;
      if (up_beat.valid) begin
         if (used_ff) begin
            rem_in = step_rem;
         end else begin
            prime_in = {prime_ff[VALUE_WIDTH-2:0], up_beat.data};
         end
         // Free the cell after an end-of-stream item has passed
         if (up_beat.last) begin
            used_in = !up_beat.eos && (used_ff || claim);
         end
      end
   end

   assign down_beat = pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         pass_ff <= '0;
      end else if (advance) begin
         used_ff <= used_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prime_ff <= prime_in;
         rem_ff   <= rem_in;
      end
   end

   // A used cell never holds a divisor below two
   assert property (@(posedge clock) disable iff (reset)
      used_ff |-> (prime_ff[VALUE_WIDTH-1:1] != '0))
      else $error("psf_cell: used cell holds a value below two");

endmodule

// File: rtl/psf_drain.sv
// ----------------------------------------------------------------------------
// psf_drain
// Output stage: gathers the bits leaving the last cell and registers a
// result beat for every item that no cell dropped. Holds the chain only
// when a result arrives while the previous one still waits.
// ----------------------------------------------------------------------------
module psf_drain #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  psf_pkg::beat_type end_beat,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_prime_value,
   output logic              rsp_overflow
);
   import psf_pkg::*;

   logic [VALUE_WIDTH-1:0] collect_ff, collect_in;
   logic                   rsp_valid_ff;
   logic [FIELD_W-1:0]     value_ff;
   logic                   ovf_ff;
   logic [EXT_W-1:0]       value_ext;
   logic                   result;

   assign collect_in = {collect_ff[VALUE_WIDTH-2:0], end_beat.data};
   assign value_ext  = EXT_W'(collect_in);
   assign result     = end_beat.valid && end_beat.last && !end_beat.drop;

   // Stall the chain only when a result would overwrite a waiting one
   assign advance = !(result && rsp_valid_ff && !rsp_ready);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = value_ff;
   assign rsp_overflow    = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Gather bits and latch the result payload
   always_ff @(posedge clock) begin
      if (advance && end_beat.valid) begin
         collect_ff <= collect_in;
      end
      if (advance && result) begin
         value_ff <= value_ext[FIELD_W-1:0];
         ovf_ff   <= !end_beat.stored;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !advance |-> (rsp_valid_ff && !rsp_ready))
      else $error("psf_drain: chain held without a blocked result");

   assert property (@(posedge clock) disable iff (reset)
      (advance && result) |=> rsp_valid_ff)
      else $error("psf_drain: arriving result not registered");

   assert property (@(posedge clock) disable iff (reset)
      (advance && result) |=> (ovf_ff == !$past(end_beat.stored)))
      else $error("psf_drain: overflow flag disagrees with stored tag");

endmodule

// File: rtl/prime_sieve_filter_chain.sv
// ----------------------------------------------------------------------------
// prime_sieve_filter_chain
// Pipelined prime sieve: a row of cells, each holding one prime, tests a
// stream of candidates and passes on the ones no stored prime divides.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries candidates (normally ascending from 2) with an end-of-stream
//   mark; rsp_* returns each candidate that no stored prime divides, with
//   rsp_overflow set when every cell was already full and it was not stored.
//   Values below two and divisible values give no response beat.
//   Each candidate walks the chain MSB first, one bit per cycle while the
//   chain advances, and each cell forms its remainder bit-serially, so the
//   feed takes a new candidate only as the last bit of the previous one
//   goes out. Many candidates are in the chain at once.
//   A response appears once the last bit of its candidate has passed every cell.
//   An end-of-stream item empties each cell as it passes, after its own test.
//   Reset empties the chain and the response register at once.
//   When the receiver stalls, the chain keeps running until a response
//   reaches the end while the previous one is still waiting; only then
//   do the whole chain and the input side hold.
// ----------------------------------------------------------------------------
module prime_sieve_filter_chain #(
   parameter int NUM_CELLS   = psf_pkg::NUM_CELLS_DEF,
   parameter int VALUE_WIDTH = psf_pkg::VALUE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_candidate,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_prime_value,
   output logic        rsp_overflow
);
   import psf_pkg::*;

   beat_type chain [NUM_CELLS+1];
   logic     advance;

   // Serialize accepted candidates into the chain
   psf_feed #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_feed (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_candidate     (req_candidate),
      .req_end_of_stream (req_end_of_stream),
      .feed_beat         (chain[0])
   );

   // Row of sieve cells
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      psf_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_beat   (chain[i]),
         .down_beat (chain[i+1])
      );
   end

   // Collect survivors and drive the response channel
   psf_drain #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_drain (
      .clock           (clock),
      .reset           (reset),
      .end_beat        (chain[NUM_CELLS]),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prime sieve filter chain. A queue of candidates
// (corner values, a long ascending run of primes, then random ascending runs
// and raw noise) feeds a valid/ready driver. Each
// accepted beat updates a local copy of the stored primes and queues the
// prime it should produce. A monitor compares every response beat with that
// queue. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   import psf_pkg::*;

   localparam int NUM_CELLS      = NUM_CELLS_DEF;
   localparam int VALUE_WIDTH    = VALUE_WIDTH_DEF;
   localparam int LATENCY        = NUM_CELLS + VALUE_WIDTH + 1;
   localparam int WATCHDOG_LIMIT = 10 * LATENCY;
   localparam int TOTAL_ITEMS    = 1300;
   localparam int FILL_PRIMES    = 400;

   typedef struct packed {
      logic [FIELD_W-1:0] candidate;
      logic               end_of_stream;
   } sieve_item_type;

   typedef struct packed {
      logic [FIELD_W-1:0] prime_value;
      logic               overflow;
   } prime_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [FIELD_W-1:0] req_candidate = '0;
   logic               req_end_of_stream = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FIELD_W-1:0] rsp_prime_value;
   logic               rsp_overflow;

   // Stimulus and expectations
   sieve_item_type     pending_items[$];
   sieve_item_type     next_item;
   prime_result_type   expected_primes[$];
   prime_result_type   oldest_prime;

   // Local copy of the chain contents
   logic [FIELD_W-1:0] prime_store[NUM_CELLS];
   int                 primes_held = 0;

   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 send_gap = 0;
   int                 hold_left = 0;
   int                 calm_left = 0;
   logic               calm = 1'b0;

   prime_sieve_filter_chain #(
      .NUM_CELLS   (NUM_CELLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_candidate     (req_candidate),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_prime_value   (rsp_prime_value),
      .rsp_overflow      (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Test a candidate against the stored primes, queue its prime, store it
   function automatic void predict_sieve(input logic [FIELD_W-1:0] cand,
                                         input logic eos);
      prime_result_type res;
      bit               divided;
      int               i;
      divided = 1'b0;
      if (cand >= 2) begin
         for (i = 0; i < primes_held; i++) begin
            if (cand % prime_store[i] == 0) begin
               divided = 1'b1;
               break;
            end
         end
         if (!divided) begin
            res.prime_value = cand;
            res.overflow    = (primes_held >= NUM_CELLS);
            if (!res.overflow) begin
               prime_store[primes_held] = cand;
               primes_held++;
            end
            expected_primes.push_back(res);
         end
      end
      // end of stream empties the chain after its own test
      if (eos)
         primes_held = 0;
   endfunction

   // Mostly short gaps, a few long ones, none during a calm stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   function automatic bit is_prime(input int n);
      int d;
      if (n < 2)
         return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic add_item(input int cand, input bit eos);
      sieve_item_type item;
      item.candidate     = FIELD_W'(cand);
      item.end_of_stream = eos;
      pending_items.push_back(item);
   endtask

   // Switch between idling and no-idling stretches
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm      <= ($urandom_range(0, 2) == 0);
         calm_left <= $urandom_range(200, 800);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // Driver: retire the accepted beat, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            predict_sieve(req_candidate, req_end_of_stream);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
               next_item          = pending_items.pop_front();
               req_candidate     <= next_item.candidate;
               req_end_of_stream <= next_item.end_of_stream;
               req_valid         <= 1'b1;
               send_gap          <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: hold ready low for random stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 7) == 0)
            hold_left <= pick_gap();
      end
   end

   // Monitor: compare each response beat with the oldest expected prime
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_primes.size() == 0) begin
            $error("unexpected beat: prime_value %0d overflow %0b",
                   rsp_prime_value, rsp_overflow);
            error_count++;
         end else begin
            oldest_prime = expected_primes.pop_front();
            if (rsp_prime_value !== oldest_prime.prime_value) begin
               $error("prime_value: expected %0d, actual %0d",
                      oldest_prime.prime_value, rsp_prime_value);
               error_count++;
            end
            if (rsp_overflow !== oldest_prime.overflow) begin
               $error("overflow: expected %0b, actual %0b",
                      oldest_prime.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // Watchdog: stop when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** prime_sieve_filter_chain: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int v;
      int len;
      int n;
      int k;

      // Corner values: small, divisible, extremes
      add_item(0, 1'b0);
      add_item(1, 1'b0);
      add_item(2, 1'b0);
      add_item(3, 1'b0);
      add_item(4, 1'b0);
      add_item(5, 1'b0);
      add_item(9, 1'b0);
      add_item(25, 1'b0);
      add_item(65535, 1'b0);
      add_item(65521, 1'b1);
      // Out of order: composite ahead of its factor is kept
      add_item(49, 1'b0);
      add_item(7, 1'b0);
      add_item(343, 1'b0);
      // End mark on a small value still clears
      add_item(1, 1'b1);
      add_item(4, 1'b0);
      add_item(8, 1'b0);
      // End mark on a divisible value still clears
      add_item(2, 1'b0);
      add_item(6, 1'b1);
      add_item(6, 1'b1);
      add_item(65535, 1'b0);
      add_item(32768, 1'b0);
      add_item(65535, 1'b1);

      // Long ascending run of primes with a little noise
      n = 0;
      v = 2;
      while (n < FILL_PRIMES) begin
         if (is_prime(v)) begin
            add_item(v, 1'b0);
            n++;
            if ($urandom_range(0, 19) == 0)
               add_item($urandom_range(0, 65535), 1'b0);
         end
         v++;
      end
      add_item(v * 3, 1'b0);
      add_item(65521, 1'b1);
      add_item(4, 1'b0);
      add_item(8, 1'b1);

      // Random ascending runs with noise, and raw noise bursts
      while (pending_items.size() < TOTAL_ITEMS) begin
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               v   = 2;
               len = $urandom_range(200, 600);
            end else begin
               v   = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 60000) : 2;
               len = $urandom_range(5, 120);
            end
            for (k = 0; k < len && pending_items.size() < TOTAL_ITEMS; k++) begin
               if ($urandom_range(0, 19) == 0)
                  add_item($urandom_range(0, 65535), 1'b0);
               add_item(v, k == len - 1);
               v = v + (($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1);
            end
         end else begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
               add_item($urandom_range(0, 65535), $urandom_range(0, 4) == 0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: all beats sent, all primes seen, then a latency's grace
      while (pending_items.size() != 0 || req_valid)
         @(negedge clock);
      while (expected_primes.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 50) @(negedge clock);

      if (error_count == 0 && expected_primes.size() == 0) begin
         $display("** prime_sieve_filter_chain: PASSED **");
      end else begin
         $display("** prime_sieve_filter_chain: FAILED **");
      end
      $finish;
   end

endmodule
